FILE: rtl/gf2rr_pkg.sv
// Package for the GF(2) row reducer: payload structs and fixed constants.
// No dependencies.
package gf2rr_pkg;

    localparam int NUM_COLS = 1024;
    localparam int WORD_W   = 64;
    localparam int IDX_W    = 4;
    localparam int COL_W    = 10;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_REDUCE = 1'b1;
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_WORD  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] word_bits;
        logic              row_end;
    } in_word_t;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  out_index;
        logic [WORD_W-1:0] out_bits;
        logic [COL_W-1:0]  lead_col;
        logic              row_zero;
        logic              out_last;
    } out_word_t;

    // Highest set bit of a 64-bit word.
    function automatic logic [5:0] msb64(input logic [WORD_W-1:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) r = 6'(i);
        end
        return r;
    endfunction

endpackage

FILE: rtl/gf2rr_pivot_mem.sv
// Pivot row store: one write port, one registered read port.
// Depends on gf2rr_pkg.
module gf2rr_pivot_mem import gf2rr_pkg::*; #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data
);
    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: rtl/gf2_row_reducer_unit.sv
// Top level of the GF(2) row reducer: gather, scan/XOR sequencer, emit.
// Depends on gf2rr_pkg and gf2rr_pivot_mem.
// On row_end the row is scanned word by word; each pivot applied takes a rescan, flag check,
// NW reads and the XOR; a new pivot is written as NW words (after a flag check on a reduce),
// then NW result words or one ack go out. Input is not ready meanwhile.
// Reset: a clearing pass writes all NUM_COLS valid flags, with input not ready.
module gf2_row_reducer_unit import gf2rr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);
    localparam int NW  = NUM_COLS / WORD_W;
    localparam int WIW = (NW > 1) ? $clog2(NW) : 1;
    localparam int CW  = $clog2(NUM_COLS);
    localparam int AW  = CW + WIW;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CLEAR = 9'b000000010,
        ST_SCAN  = 9'b000000100,
        ST_CHK   = 9'b000001000,
        ST_RD    = 9'b000010000,
        ST_XOR   = 9'b000100000,
        ST_STORE = 9'b001000000,
        ST_EMIT  = 9'b010000000,
        ST_ACK   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [WORD_W-1:0] row_reg [NW];
    logic           pvalid_mem [NUM_COLS];
    logic           pv_rd_reg;
    logic [CW-1:0]  clr_reg;
    logic [WIW-1:0] w_reg;       // scan / store / emit word pointer
    logic [WIW:0]   cnt_reg;     // words issued or done
    logic [CW-1:0]  lead_reg;
    logic           found_reg, cmd_reg;
    logic           m_valid_reg;
    out_word_t      m_data_reg;

    logic [WORD_W-1:0] rd_data;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic              pv_wr_en;
    logic [CW-1:0]     pv_wr_addr;
    logic              pv_wr_data;

    wire accept_in  = s_valid && s_ready;
    wire out_free   = !m_valid_reg || m_ready;
    wire [CW-1:0] scan_col = {w_reg, msb64(row_reg[w_reg])};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Reads issue in ST_RD (count 0..NW-1); data lands in the next cycle.
    assign rd_addr = {lead_reg, cnt_reg[WIW-1:0]};
    assign wr_en   = (state_reg == ST_STORE);

    // Valid flags: cleared by a pass after reset, set on the last store cycle.
    assign pv_wr_en   = (state_reg == ST_CLEAR) ||
                        (state_reg == ST_STORE && w_reg == WIW'(NW - 1));
    assign pv_wr_addr = (state_reg == ST_CLEAR) ? clr_reg : lead_reg;
    assign pv_wr_data = (state_reg == ST_STORE);

    gf2rr_pivot_mem #(.DEPTH(NUM_COLS * NW), .AW(AW)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr ({lead_reg, w_reg}),
        .wr_data (row_reg[w_reg]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Flag of the column under scan is ready in ST_CHK.
    always_ff @(posedge aclk) begin
        if (pv_wr_en) pvalid_mem[pv_wr_addr] <= pv_wr_data;
        pv_rd_reg <= pvalid_mem[scan_col];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept_in && s_data.row_end) state_next = ST_SCAN;
            ST_CLEAR: if (clr_reg == CW'(NUM_COLS - 1)) state_next = ST_IDLE;
            ST_SCAN: begin
                if (row_reg[w_reg] != '0) begin
                    if (cmd_reg == CMD_REDUCE) state_next = ST_CHK;
                    else state_next = ST_STORE;
                end else if (w_reg == '0) begin
                    state_next = (cmd_reg == CMD_LOAD) ? ST_ACK : ST_EMIT;
                end
            end
            ST_CHK:   state_next = pv_rd_reg ? ST_RD : ST_STORE;
            ST_RD:    if (cnt_reg == (WIW+1)'(NW - 1)) state_next = ST_XOR;
            ST_XOR:   state_next = ST_SCAN;
            ST_STORE: if (w_reg == WIW'(NW - 1))
                          state_next = (cmd_reg == CMD_LOAD) ? ST_ACK : ST_EMIT;
            ST_EMIT:  if (out_free && w_reg == WIW'(NW - 1)) state_next = ST_IDLE;
            ST_ACK:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            w_reg       <= '0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            for (int i = 0; i < NW; i++) row_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_EMIT || state_reg == ST_ACK) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (accept_in) begin
                        if ({1'b0, s_data.word_index} < (IDX_W+1)'(NW))
                            row_reg[s_data.word_index[WIW-1:0]] <= s_data.word_bits;
                        if (s_data.row_end) begin
                            cmd_reg   <= s_data.cmd;
                            w_reg     <= WIW'(NW - 1);
                            found_reg <= 1'b0;
                        end
                    end
                end
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                end
                ST_SCAN: begin
                    if (row_reg[w_reg] != '0) begin
                        lead_reg <= scan_col;
                        cnt_reg  <= '0;
                        if (cmd_reg == CMD_LOAD) begin
                            found_reg <= 1'b1;
                            w_reg     <= '0;
                        end
                    end else if (w_reg == '0) begin
                        w_reg <= '0;
                    end else begin
                        w_reg <= w_reg - 1'b1;
                    end
                end
                ST_CHK: begin
                    if (!pv_rd_reg) begin
                        found_reg <= 1'b1;
                        w_reg     <= '0;
                    end
                end
                ST_RD: begin
                    // apply the word read last cycle
                    if (cnt_reg != '0)
                        row_reg[cnt_reg[WIW-1:0] - 1'b1] <=
                            row_reg[cnt_reg[WIW-1:0] - 1'b1] ^ rd_data;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_XOR: begin
                    row_reg[WIW'(NW - 1)] <= row_reg[WIW'(NW - 1)] ^ rd_data;
                end
                ST_STORE: begin
                    if (w_reg == WIW'(NW - 1)) begin
                        w_reg <= '0;
                    end else begin
                        w_reg <= w_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_data_reg.kind      <= KIND_WORD;
                        m_data_reg.out_index <= IDX_W'(w_reg);
                        m_data_reg.out_bits  <= row_reg[w_reg];
                        m_data_reg.lead_col  <= found_reg ? COL_W'(lead_reg) : '0;
                        m_data_reg.row_zero  <= !found_reg;
                        m_data_reg.out_last  <= (w_reg == WIW'(NW - 1));
                        row_reg[w_reg]       <= '0;
                        w_reg                <= w_reg + 1'b1;
                    end
                end
                ST_ACK: begin
                    if (out_free) begin
                        m_data_reg.kind      <= KIND_ACK;
                        m_data_reg.out_index <= '0;
                        m_data_reg.out_bits  <= '0;
                        m_data_reg.lead_col  <= found_reg ? COL_W'(lead_reg) : '0;
                        m_data_reg.row_zero  <= !found_reg;
                        m_data_reg.out_last  <= 1'b1;
                        for (int i = 0; i < NW; i++) row_reg[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(state_reg == ST_EMIT)) else $error("ready while emitting");
    a_zero_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.row_zero) |-> (m_data.lead_col == '0))
        else $error("zero row with lead");
`endif

endmodule

FILE: tb/sv/gf2rr_checker.sv
// Checker for the GF(2) row reducer: watches both channels, predicts results.
// Depends on gf2rr_pkg.
module gf2rr_checker import gf2rr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        fail_count,
    output int        pending
);
    localparam int NCOLS = NUM_COLS;
    localparam int NW    = NCOLS / WORD_W;

    logic [WORD_W-1:0] pivot_store [0:NCOLS*NW-1];
    logic [NCOLS-1:0]  pivot_used = '0;
    logic [WORD_W-1:0] gathered [0:NW-1] = '{default: '0};
    out_word_t         expected_q [$];
    int                n_fail = 0;
    int                n_pend = 0;

    assign fail_count = n_fail;
    assign pending    = n_pend;

    function automatic logic col_set(input int c);
        return gathered[c / WORD_W][c % WORD_W];
    endfunction

    task automatic absorb_word(input in_word_t iw);
        out_word_t r;
        int        lead;
        logic      found;
        lead  = 0;
        found = 1'b0;
        if (int'(iw.word_index) < NW) gathered[iw.word_index] = iw.word_bits;
        if (!iw.row_end) return;
        for (int c = NCOLS - 1; c >= 0 && !found; c--) begin
            if (!col_set(c)) continue;
            if (iw.cmd == CMD_REDUCE && pivot_used[c]) begin
                for (int w = 0; w < NW; w++) gathered[w] ^= pivot_store[c*NW + w];
            end else begin
                lead  = c;
                found = 1'b1;
            end
        end
        if (found) begin
            for (int w = 0; w < NW; w++) pivot_store[lead*NW + w] = gathered[w];
            pivot_used[lead] = 1'b1;
        end
        if (iw.cmd == CMD_LOAD) begin
            r = '{kind: KIND_ACK, out_index: '0, out_bits: '0, lead_col: COL_W'(lead),
                  row_zero: !found, out_last: 1'b1};
            expected_q.push_back(r);
        end else begin
            for (int w = 0; w < NW; w++) begin
                r = '{kind: KIND_WORD, out_index: IDX_W'(w), out_bits: gathered[w],
                      lead_col: COL_W'(lead), row_zero: !found, out_last: (w == NW - 1)};
                expected_q.push_back(r);
            end
        end
        for (int w = 0; w < NW; w++) gathered[w] = '0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) absorb_word(s_data);
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result word: %p", m_data);
            end else begin
                out_word_t e;
                e = expected_q.pop_front();
                if (m_data !== e) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: expected %p, got %p", e, m_data);
                end
            end
        end
        n_pend = expected_q.size();
    end
endmodule

FILE: tb/sv/tb.sv
// Testbench top for gf2_row_reducer_unit: clock, reset, stimulus, verdict.
// Depends on gf2rr_pkg, gf2rr_checker and the block itself.
module tb;
    import gf2rr_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    int        fail_count;
    int        pending;
    int        tx_idle_pct = 18;
    int        rx_idle_pct = 86;
    logic      rx_hold = 1'b0;

    always #6 aclk = ~aclk;

    gf2_row_reducer_unit DUT (.*);

    gf2rr_checker u_checker (.*);

    always @(posedge aclk)
        m_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    task automatic send_word(input logic cmd, input int idx, input logic [63:0] bits,
                             input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{cmd: cmd, word_index: IDX_W'(idx), word_bits: bits, row_end: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_bits();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // random row: a few words at random indexes, row_end on the last
    task automatic send_row(input logic cmd);
        int n;
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++)
            send_word(1'($urandom_range(1)), int'($urandom_range(15)), rand_bits(), 1'b0);
        send_word(cmd, int'($urandom_range(15)), rand_bits(), 1'b1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero row load, extremes of the column range, all-ones word
        send_word(CMD_LOAD, 3, '0, 1'b1);
        send_word(CMD_LOAD, 15, 64'h8000_0000_0000_0000, 1'b1);
        send_word(CMD_LOAD, 0, 64'h1, 1'b1);
        send_word(CMD_REDUCE, 15, '1, 1'b0);
        send_word(CMD_REDUCE, 0, '1, 1'b1);
        // reduce against stored pivots down to zero
        send_word(CMD_REDUCE, 15, 64'h8000_0000_0000_0000, 1'b0);
        send_word(CMD_REDUCE, 0, 64'h1, 1'b1);
        // rewrite of the same word, then mixed commands
        send_word(CMD_LOAD, 7, 64'hFFFF, 1'b0);
        send_word(CMD_REDUCE, 7, 64'h5A5A_0000_0000_0000, 1'b0);
        send_word(CMD_LOAD, 2, 64'h3, 1'b1);
        // reload an existing pivot column
        send_word(CMD_LOAD, 15, 64'hC000_0000_0000_0001, 1'b1);
        send_word(CMD_REDUCE, 15, 64'hC000_0000_0000_0000, 1'b1);
        send_word(CMD_REDUCE, 9, '0, 1'b1);
        drain();

        for (int i = 0; i < 40; i++) send_row(1'($urandom_range(1)));
        // sender keeps offering while the receiver holds off
        fork
            begin
                rx_hold = 1'b1;
                repeat (600) @(posedge aclk);
                rx_hold = 1'b0;
            end
            for (int i = 0; i < 12; i++) send_row(CMD_REDUCE);
        join
        drain();

        tx_idle_pct = 86;
        rx_idle_pct = 18;
        for (int i = 0; i < 40; i++) send_row(1'($urandom_range(1)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < 40; i++) send_row(1'($urandom_range(1)));
        drain();
        repeat (200) @(posedge aclk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #(12 * 30_000_000);
        $display("Regression FAIL");
        $finish;
    end
endmodule
